### src/srtrb_pkg.sv
// Shared types and constants for the serial receive/transmit ring buffers.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package srtrb_pkg;

    localparam int RX_DEPTH_DEF = 128;
    localparam int TX_DEPTH_DEF = 64;

    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int RX_COUNT_W = 7;
    localparam int TX_COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_LINE_RX  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_RD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOST_WR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH_RX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLR_ABRT = 3'd5;

    localparam logic [BYTE_W-1:0] CTRL_X = 8'h18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture transaction and read both stores at their tails
        logic exec;   // apply the command and register the result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### src/srtrb_ctrl.sv
// Sequencing state machine for the ring buffers: accept, execute, respond.
// Depends on srtrb_pkg.
`default_nettype none

module srtrb_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    output logic                done,
    output srtrb_pkg::ctrl_cmd_t ctrl
);

    srtrb_pkg::state_t state_reg;
    srtrb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srtrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srtrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = srtrb_pkg::ST_EXEC;
                end
            end
            srtrb_pkg::ST_EXEC:
            begin
                state_next = srtrb_pkg::ST_RESP;
            end
            srtrb_pkg::ST_RESP:
            begin
                // take the next transaction while the result is on the ports
                if (start)
                begin
                    state_next = srtrb_pkg::ST_EXEC;
                end
                else
                begin
                    state_next = srtrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srtrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        done      = 1'b0;
        ctrl.load = 1'b0;
        ctrl.exec = 1'b0;
        case (state_reg)
            srtrb_pkg::ST_IDLE:
            begin
                ctrl.load = start;
            end
            srtrb_pkg::ST_EXEC:
            begin
                busy      = 1'b1;
                ctrl.exec = 1'b1;
            end
            srtrb_pkg::ST_RESP:
            begin
                done      = 1'b1;
                ctrl.load = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/srtrb_dpath.sv
// Datapath: receive and transmit byte stores, pointers, abort flag, result registers.
// Depends on srtrb_pkg; driven by srtrb_ctrl.
`default_nettype none

module srtrb_dpath
#(
    parameter int RX_DEPTH = srtrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = srtrb_pkg::TX_DEPTH_DEF
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  srtrb_pkg::ctrl_cmd_t                 ctrl,
    input  wire  [srtrb_pkg::CMD_W-1:0]          cmd,
    input  wire  [srtrb_pkg::BYTE_W-1:0]         byte_value,
    output logic [srtrb_pkg::BYTE_W-1:0]         out_byte,
    output logic                                 out_valid,
    output logic                                 accepted,
    output logic                                 abort_latched,
    output logic                                 power_off_pulse,
    output logic                                 tx_active,
    output logic [srtrb_pkg::RX_COUNT_W-1:0]     rx_count,
    output logic [srtrb_pkg::TX_COUNT_W-1:0]     tx_count
);

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam logic [RX_PW:0]   RX_DEPTH_V = RX_DEPTH[RX_PW:0];
    localparam logic [TX_PW:0]   TX_DEPTH_V = TX_DEPTH[TX_PW:0];
    localparam logic [RX_PW-1:0] RX_LAST    = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST    = TX_PW'(TX_DEPTH - 1);

    logic [srtrb_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [srtrb_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];

    logic [RX_PW-1:0] rx_head_reg, rx_head_next;
    logic [RX_PW-1:0] rx_tail_reg, rx_tail_next;
    logic [TX_PW-1:0] tx_head_reg, tx_head_next;
    logic [TX_PW-1:0] tx_tail_reg, tx_tail_next;
    logic             abort_reg, abort_next;

    logic [srtrb_pkg::CMD_W-1:0]  cmd_reg;
    logic [srtrb_pkg::BYTE_W-1:0] byte_reg;
    logic [srtrb_pkg::BYTE_W-1:0] rx_rd_reg;
    logic [srtrb_pkg::BYTE_W-1:0] tx_rd_reg;

    logic [RX_PW-1:0] rx_head_adv, rx_tail_adv;
    logic [TX_PW-1:0] tx_head_adv, tx_tail_adv;
    logic             rx_we, tx_we;
    logic [srtrb_pkg::BYTE_W-1:0] ob_next;
    logic             ovalid_next, acc_next, pulse_next;
    logic [RX_PW:0]   rx_occ;
    logic [TX_PW:0]   tx_occ;

    assign rx_head_adv = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_adv = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_adv = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_adv = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        abort_next   = abort_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        ob_next      = '0;
        ovalid_next  = 1'b0;
        acc_next     = 1'b0;
        pulse_next   = 1'b0;
        case (cmd_reg)
            srtrb_pkg::CMD_LINE_RX:
            begin
                if (byte_reg == srtrb_pkg::CTRL_X)
                begin
                    abort_next = 1'b1;
                    pulse_next = 1'b1;
                end
                else if (!abort_reg && (rx_head_adv != rx_tail_reg))
                begin
                    rx_we        = 1'b1;
                    rx_head_next = rx_head_adv;
                    acc_next     = 1'b1;
                end
            end
            srtrb_pkg::CMD_HOST_RD:
            begin
                if (rx_head_reg != rx_tail_reg)
                begin
                    ob_next      = rx_rd_reg;
                    ovalid_next  = 1'b1;
                    rx_tail_next = rx_tail_adv;
                end
            end
            srtrb_pkg::CMD_HOST_WR:
            begin
                if (tx_head_adv != tx_tail_reg)
                begin
                    tx_we        = 1'b1;
                    tx_head_next = tx_head_adv;
                    acc_next     = 1'b1;
                end
            end
            srtrb_pkg::CMD_TX_READY:
            begin
                if (tx_head_reg != tx_tail_reg)
                begin
                    ob_next      = tx_rd_reg;
                    ovalid_next  = 1'b1;
                    tx_tail_next = tx_tail_adv;
                end
            end
            srtrb_pkg::CMD_FLUSH_RX:
            begin
                rx_tail_next = rx_head_reg;
            end
            srtrb_pkg::CMD_CLR_ABRT:
            begin
                abort_next = 1'b0;
            end
            default:
            begin
                abort_next = abort_reg;
            end
        endcase
    end

    // Occupancy after this transaction
    always_comb
    begin
        if (rx_head_next >= rx_tail_next)
        begin
            rx_occ = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
        end
        else
        begin
            rx_occ = RX_DEPTH_V - ({1'b0, rx_tail_next} - {1'b0, rx_head_next});
        end
        if (tx_head_next >= tx_tail_next)
        begin
            tx_occ = {1'b0, tx_head_next} - {1'b0, tx_tail_next};
        end
        else
        begin
            tx_occ = TX_DEPTH_V - ({1'b0, tx_tail_next} - {1'b0, tx_head_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            abort_reg   <= 1'b0;
        end
        else if (ctrl.exec)
        begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            abort_reg   <= abort_next;
        end
    end

    // Capture the transaction and pre-read both stores at their tails
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd;
            byte_reg  <= byte_value;
            rx_rd_reg <= rx_mem[rx_tail_reg];
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && rx_we)
        begin
            rx_mem[rx_head_reg] <= byte_reg;
        end
        if (ctrl.exec && tx_we)
        begin
            tx_mem[tx_head_reg] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            out_byte        <= ob_next;
            out_valid       <= ovalid_next;
            accepted        <= acc_next;
            abort_latched   <= abort_next;
            power_off_pulse <= pulse_next;
            tx_active       <= (tx_occ != '0);
            rx_count        <= srtrb_pkg::RX_COUNT_W'(rx_occ);
            tx_count        <= srtrb_pkg::TX_COUNT_W'(tx_occ);
        end
    end

endmodule

`default_nettype wire

### src/serial_rx_tx_ring_buffers_top.sv
// The result strobe (done) is raised in ST_RESP, reached through ST_EXEC after the accepting edge.
// Transactions are spaced by the registered store read followed by the update in ST_EXEC;
// start is ignored while busy and is taken again while done is high.
// Reset clears both queues' pointers and the abort flag; store contents stay undefined.
// done lasts one cycle and the receiver cannot stall it.
// Top level of the serial receive/transmit ring buffers; uses srtrb_pkg, srtrb_ctrl,
// srtrb_dpath.
`default_nettype none

module serial_rx_tx_ring_buffers_top
#(
    parameter int RX_DEPTH = srtrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = srtrb_pkg::TX_DEPTH_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [srtrb_pkg::CMD_W-1:0]      cmd,
    input  wire  [srtrb_pkg::BYTE_W-1:0]     byte_value,
    output logic                             done,
    output logic [srtrb_pkg::BYTE_W-1:0]     out_byte,
    output logic                             out_valid,
    output logic                             accepted,
    output logic                             abort_latched,
    output logic                             power_off_pulse,
    output logic                             tx_active,
    output logic [srtrb_pkg::RX_COUNT_W-1:0] rx_count,
    output logic [srtrb_pkg::TX_COUNT_W-1:0] tx_count
);

    srtrb_pkg::ctrl_cmd_t ctrl;

    srtrb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    srtrb_dpath
    #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .cmd             (cmd),
        .byte_value      (byte_value),
        .out_byte        (out_byte),
        .out_valid       (out_valid),
        .accepted        (accepted),
        .abort_latched   (abort_latched),
        .power_off_pulse (power_off_pulse),
        .tx_active       (tx_active),
        .rx_count        (rx_count),
        .tx_count        (tx_count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter execution");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding execution cycle");

    a_pulse_sets_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (done && power_off_pulse) |-> abort_latched)
        else $error("control-X result without abort flag");

    a_valid_xor_acc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid && accepted))
        else $error("result both dequeued and stored a byte");

endmodule

`default_nettype wire
